// ----- hdl/iirdf2t_pkg.sv -----
// ---------------------------------------------------------------------------
// iirdf2t_pkg: shared types and constants of the transposed DF-II IIR filter
// Field widths, fixed-point format, register indexes and controller commands.
// ---------------------------------------------------------------------------
package iirdf2t_pkg;

  // Default filter order (number of delay registers), range 1..3
  localparam int unsigned ORDER_DEF = 3;

  // Field and datapath widths
  localparam int unsigned SAMPLE_W   = 16;  // input and output samples
  localparam int unsigned COEF_W     = 24;  // Q4.20 coefficients
  localparam int unsigned FRAC_W     = 20;  // fraction bits of coefficients and delays
  localparam int unsigned DLY_W      = 48;  // delay registers and y, twice COEF_W
  localparam int unsigned PROD_W     = 49;  // COEF_W x (COEF_W + 1) signed product
  localparam int unsigned ACC_W      = 56;  // accumulator with headroom
  localparam int unsigned NUM_TAPS   = 4;   // stored coefficients per bank
  localparam int unsigned COEF_IDX_W = 2;   // index into a coefficient bank
  localparam int unsigned CFG_IDX_W  = 3;   // config register index

  // Reset value of b0: 1.0 in Q4.20
  localparam logic signed [COEF_W-1:0] B0_RESET = COEF_W'(1 << FRAC_W);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_COEF_0 = 3'd0,
    REG_NUM_COEF_1 = 3'd1,
    REG_NUM_COEF_2 = 3'd2,
    REG_NUM_COEF_3 = 3'd3,
    REG_DEN_COEF_1 = 3'd4,
    REG_DEN_COEF_2 = 3'd5,
    REG_DEN_COEF_3 = 3'd6
  } cfg_reg_e;

  // Multiplier operand selection
  typedef enum logic [1:0] {
    MUL_BX,   // b[tap] * x
    MUL_AHI,  // a[tap] * upper half of y
    MUL_ALO   // a[tap] * lower half of y (unsigned)
  } mul_sel_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_Y_MUL,
    ST_Y_ACC,
    ST_T_BX,
    ST_T_AHI,
    ST_T_ALO,
    ST_T_WR,
    ST_DONE
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;      // capture input transaction
    logic     restart;   // clear delays with the load
    logic     mul_en;    // register a new product
    mul_sel_e mul_sel;
    logic     y_acc;     // y = sat(b0*x + d0)
    logic     acc_init;  // acc = d[tap] + b[tap]*x
    logic     acc_hi;    // acc -= 16 * a[tap]*hi
    logic     d_wr;      // d[tap-1] = sat(acc - rnd(a[tap]*lo))
    logic     out_load;  // move rounded y into output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_full;      // output register holds a result that is not taken this cycle
  } dp_status_t;

  // Saturate an accumulator value to the 48-bit delay range
  function automatic logic signed [DLY_W-1:0] sat_dly(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] vmax;
    logic signed [ACC_W-1:0] vmin;
    vmax = {{(ACC_W-DLY_W+1){1'b0}}, {(DLY_W-1){1'b1}}};
    vmin = {{(ACC_W-DLY_W+1){1'b1}}, {(DLY_W-1){1'b0}}};
    if (v > vmax) begin
      return vmax[DLY_W-1:0];
    end else if (v < vmin) begin
      return vmin[DLY_W-1:0];
    end
    return v[DLY_W-1:0];
  endfunction

endpackage

// ----- hdl/iirdf2t_ctrl.sv -----
// ---------------------------------------------------------------------------
// iirdf2t_ctrl: sequencer of the IIR filter
// Walks one sample through the y product and the per-tap update steps.
// ---------------------------------------------------------------------------
module iirdf2t_ctrl #(
  parameter int unsigned ORDER = iirdf2t_pkg::ORDER_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic                         restart_i,
  input  iirdf2t_pkg::dp_status_t      status_i,
  output iirdf2t_pkg::dp_cmd_t         cmd_o,
  output logic [$clog2(ORDER+1)-1:0]   tap_o
);
  import iirdf2t_pkg::*;

  localparam int unsigned TAP_W = $clog2(ORDER + 1);

  state_e           state_q, state_d;
  logic [TAP_W-1:0] tap_q, tap_d;
  logic             accept;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign tap_o         = tap_q;

  // State and tap counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tap_q   <= '0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    tap_d         = tap_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MUL_BX;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_o.load    = 1'b1;
          cmd_o.restart = restart_i;
          tap_d         = '0;
          state_d       = ST_Y_MUL;
        end
      end
      ST_Y_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_BX;
        state_d       = ST_Y_ACC;
      end
      ST_Y_ACC: begin
        cmd_o.y_acc = 1'b1;
        tap_d       = TAP_W'(1);
        state_d     = ST_T_BX;
      end
      ST_T_BX: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_BX;
        state_d       = ST_T_AHI;
      end
      ST_T_AHI: begin
        cmd_o.acc_init = 1'b1;
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MUL_AHI;
        state_d        = ST_T_ALO;
      end
      ST_T_ALO: begin
        cmd_o.acc_hi  = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_ALO;
        state_d       = ST_T_WR;
      end
      ST_T_WR: begin
        cmd_o.d_wr = 1'b1;
        if (tap_q == TAP_W'(ORDER)) begin
          state_d = ST_DONE;
        end else begin
          tap_d   = tap_q + TAP_W'(1);
          state_d = ST_T_BX;
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!status_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // A sample always starts with the b0 product
  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_Y_MUL) && (tap_q == '0))
    else $error("sample did not start at tap zero");

  // Delay writes only hit existing taps
  a_wr_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.d_wr |-> (tap_q != '0) && (tap_q <= TAP_W'(ORDER)))
    else $error("delay write outside tap range");

  // Last tap write ends the tap loop
  a_last_tap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_T_WR) && (tap_q == TAP_W'(ORDER)) |=> state_q == ST_DONE)
    else $error("tap loop overran");

endmodule

// ----- hdl/iirdf2t_datapath.sv -----
// ---------------------------------------------------------------------------
// iirdf2t_datapath: coefficients, delays, shared multiplier and output stage
// One 24x25 signed multiplier serves all b*x and split a*y products.
// ---------------------------------------------------------------------------
module iirdf2t_datapath #(
  parameter int unsigned ORDER = iirdf2t_pkg::ORDER_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  // configuration write channel
  input  logic                                       cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  logic [iirdf2t_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [iirdf2t_pkg::COEF_W-1:0]             cfg_data_i,
  // input sample
  input  logic [iirdf2t_pkg::SAMPLE_W-1:0]           s_axis_tdata,
  // control
  input  iirdf2t_pkg::dp_cmd_t                       cmd_i,
  input  logic [$clog2(ORDER+1)-1:0]                 tap_i,
  output iirdf2t_pkg::dp_status_t                    status_o,
  // output stream
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  output logic [iirdf2t_pkg::SAMPLE_W-1:0]           m_axis_tdata,
  output logic                                       m_axis_tuser
);
  import iirdf2t_pkg::*;

  localparam int unsigned TAP_W = $clog2(ORDER + 1);
  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'd1 << (FRAC_W - 1));
  localparam logic signed [ACC_W-1:0] OUT_MAX =
    {{(ACC_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] OUT_MIN =
    {{(ACC_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

  logic signed [COEF_W-1:0]   num_q [NUM_TAPS];
  logic signed [COEF_W-1:0]   den_q [NUM_TAPS];   // entry 0 unused (a0 = 1)
  logic signed [DLY_W-1:0]    d_q   [ORDER];
  logic signed [SAMPLE_W-1:0] x_q;
  logic signed [DLY_W-1:0]    y_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic                       out_valid_q;
  logic [SAMPLE_W-1:0]        out_data_q;
  logic                       out_clip_q;

  logic [COEF_IDX_W-1:0]      coef_idx;
  logic signed [COEF_W-1:0]   coef_sel;
  logic signed [COEF_W:0]     mul_b;
  logic signed [PROD_W-1:0]   prod_d;
  logic signed [DLY_W-1:0]    dsel;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    dsel_ext;
  logic signed [ACC_W-1:0]    d0_ext;
  logic signed [ACC_W-1:0]    rnd_lo;
  logic signed [DLY_W-1:0]    wr_val;
  logic signed [DLY_W-1:0]    y_val;
  logic signed [ACC_W-1:0]    y_ext;
  logic signed [ACC_W-1:0]    r_full;
  logic [SAMPLE_W-1:0]        r_sat;
  logic                       r_clip;

  assign cfg_ready_o = 1'b1;

  // Coefficient registers; writes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q[0] <= B0_RESET;
      den_q[0] <= '0;
      for (int i = 1; i < NUM_TAPS; i++) begin
        num_q[i] <= '0;
        den_q[i] <= '0;
      end
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_NUM_COEF_0: num_q[0] <= cfg_data_i;
        REG_NUM_COEF_1: num_q[1] <= cfg_data_i;
        REG_NUM_COEF_2: num_q[2] <= cfg_data_i;
        REG_NUM_COEF_3: num_q[3] <= cfg_data_i;
        REG_DEN_COEF_1: den_q[1] <= cfg_data_i;
        REG_DEN_COEF_2: den_q[2] <= cfg_data_i;
        REG_DEN_COEF_3: den_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Multiplier operands: y is split into a signed upper and unsigned lower half
  assign coef_idx = COEF_IDX_W'(tap_i);
  assign coef_sel = (cmd_i.mul_sel == MUL_BX) ? num_q[coef_idx] : den_q[coef_idx];

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_BX:  mul_b = {{(COEF_W+1-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q};
      MUL_AHI: mul_b = {y_q[DLY_W-1], y_q[DLY_W-1:DLY_W-COEF_W]};
      MUL_ALO: mul_b = {1'b0, y_q[COEF_W-1:0]};
      default: mul_b = '0;
    endcase
  end

  assign prod_d = coef_sel * mul_b;

  // Delay operand for the current tap; the top tap has none
  always_comb begin
    dsel = '0;
    for (int i = 0; i < ORDER; i++) begin
      if (tap_i == TAP_W'(i)) begin
        dsel = d_q[i];
      end
    end
  end

  // Accumulate, round and saturate
  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign dsel_ext = {{(ACC_W-DLY_W){dsel[DLY_W-1]}}, dsel};
  assign d0_ext   = {{(ACC_W-DLY_W){d_q[0][DLY_W-1]}}, d_q[0]};
  assign rnd_lo   = (prod_ext + RND_HALF) >>> FRAC_W;
  assign wr_val   = sat_dly(acc_q - rnd_lo);
  assign y_val    = sat_dly(d0_ext + prod_ext);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= s_axis_tdata;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.y_acc) begin
      y_q <= y_val;
    end
    if (cmd_i.acc_init) begin
      acc_q <= dsel_ext + prod_ext;
    end else if (cmd_i.acc_hi) begin
      acc_q <= acc_q - (prod_ext <<< (COEF_W - FRAC_W));
    end
  end

  // Delay registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ORDER; i++) begin
        d_q[i] <= '0;
      end
    end else if (cmd_i.load && cmd_i.restart) begin
      for (int i = 0; i < ORDER; i++) begin
        d_q[i] <= '0;
      end
    end else if (cmd_i.d_wr) begin
      for (int i = 0; i < ORDER; i++) begin
        if (tap_i == TAP_W'(i + 1)) begin
          d_q[i] <= wr_val;
        end
      end
    end
  end

  // Output rounding and clipping
  assign y_ext  = {{(ACC_W-DLY_W){y_q[DLY_W-1]}}, y_q};
  assign r_full = (y_ext + RND_HALF) >>> FRAC_W;

  always_comb begin
    r_clip = 1'b0;
    r_sat  = r_full[SAMPLE_W-1:0];
    if (r_full > OUT_MAX) begin
      r_clip = 1'b1;
      r_sat  = OUT_MAX[SAMPLE_W-1:0];
    end else if (r_full < OUT_MIN) begin
      r_clip = 1'b1;
      r_sat  = OUT_MIN[SAMPLE_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= r_sat;
      out_clip_q <= r_clip;
    end
  end

  assign status_o.out_full = out_valid_q && !m_axis_tready;
  assign m_axis_tvalid     = out_valid_q;
  assign m_axis_tdata      = out_data_q;
  assign m_axis_tuser      = out_clip_q;

  // Clip flag only comes with a limit value
  a_clip_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata == OUT_MAX[SAMPLE_W-1:0]) || (m_axis_tdata == OUT_MIN[SAMPLE_W-1:0]))
    else $error("clip flag without saturated sample");

  // Restart clears the delay feeding y
  a_restart_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && cmd_i.restart |=> d_q[0] == '0)
    else $error("restart did not clear delays");

  // Loading a result presents it the next cycle
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |=> m_axis_tvalid)
    else $error("loaded result not presented");

endmodule

// ----- hdl/iir_filter_df2_transposed_unit.sv -----
// ---------------------------------------------------------------------------
// iir_filter_df2_transposed_unit: streaming transposed direct form II IIR
// Fixed-point IIR filter with Q4.20 coefficients and 48-bit delay registers.
// ---------------------------------------------------------------------------
// Each input transaction carries one signed 16-bit sample and a restart flag
// that clears the delays before the sample is used; each output transaction
// carries the filtered sample, rounded half up and saturated to 16 bits, and a
// clip flag. Coefficients b0..b3, a1..a3 (a0 is one) must be written by the
// user through the configuration channel while the filter is idle; the block
// itself does not enforce this. Taps above ORDER are stored but unused. One
// shared 24x25 multiplier does all products, a*y ones in two passes, so a
// sample occupies the sequencer from acceptance until its result is loaded;
// the next sample is accepted after that, while a result may wait in the
// output register. The last step holds while an earlier result waits unread.
module iir_filter_df2_transposed_unit #(
  parameter int unsigned ORDER = iirdf2t_pkg::ORDER_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [iirdf2t_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [iirdf2t_pkg::COEF_W-1:0]    cfg_data_i,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [iirdf2t_pkg::SAMPLE_W-1:0]  s_axis_tdata,   // [15:0] sample_in
  input  logic                              s_axis_tuser,   // [0] restart
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [iirdf2t_pkg::SAMPLE_W-1:0]  m_axis_tdata,   // [15:0] sample_out
  output logic                              m_axis_tuser    // [0] clipped
);
  import iirdf2t_pkg::*;

  localparam int unsigned TAP_W = $clog2(ORDER + 1);

  dp_cmd_t          cmd;
  dp_status_t       status;
  logic [TAP_W-1:0] tap;

  // Sequencer
  iirdf2t_ctrl #(
    .ORDER (ORDER)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .restart_i     (s_axis_tuser),
    .status_i      (status),
    .cmd_o         (cmd),
    .tap_o         (tap)
  );

  // Arithmetic and storage
  iirdf2t_datapath #(
    .ORDER (ORDER)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tdata  (s_axis_tdata),
    .cmd_i         (cmd),
    .tap_i         (tap),
    .status_o      (status),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
